/* rtl/core/jfbs_pkg.sv */
// Shared types and constants for the motion JPEG frame boundary scanner.
package jfbs_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned SIZE_WIDTH   = 32;
   localparam int unsigned LENGTH_WIDTH = 16;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [BYTE_WIDTH-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] CODE_SOI      = 8'hD8;
   localparam logic [BYTE_WIDTH-1:0] CODE_EOI      = 8'hD9;
   localparam logic [BYTE_WIDTH-1:0] CODE_RST_LO   = 8'hD0;
   localparam logic [BYTE_WIDTH-1:0] CODE_RST_HI   = 8'hD7;
   localparam logic [BYTE_WIDTH-1:0] CODE_TEM      = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] CODE_STUFF    = 8'h00;

   localparam logic [SIZE_WIDTH-1:0] OFFSET_MAX = '1;

   // Register index, taken from the word address.
   localparam logic REG_IMAGE_PER_FRAME = 1'b0;

   typedef enum logic [2:0] {
      ST_START  = 3'd0,
      ST_SOI    = 3'd1,
      ST_SEARCH = 3'd2,
      ST_CODE   = 3'd3,
      ST_LENGTH = 3'd4
   } scan_state_type;

   typedef enum logic {
      KIND_FRAME   = 1'b0,
      KIND_INVALID = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic                  valid;
      result_kind_type       kind;
      logic [SIZE_WIDTH-1:0] frame_size;
   } scan_result_type;

   typedef struct packed {
      scan_state_type        state;
      logic [SIZE_WIDTH-1:0] byte_offset;
   } scan_status_type;

endpackage

/* rtl/core/jfbs_csr.sv */
// APB-style configuration register block holding the field mode setting.
module jfbs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [jfbs_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [jfbs_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [jfbs_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready,
   output logic                                 image_per_frame
);
   import jfbs_pkg::*;

   logic image_per_frame_ff;
   logic image_per_frame_in;
   logic write_hit;

   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && pready &&
                      (paddr[CSR_ADDR_WIDTH-1] == REG_IMAGE_PER_FRAME);

   always_comb begin
      image_per_frame_in = image_per_frame_ff;
      if (write_hit) begin
         image_per_frame_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_per_frame_ff <= 1'b0;
      end else begin
         image_per_frame_ff <= image_per_frame_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_WIDTH-1] == REG_IMAGE_PER_FRAME) begin
         prdata[0] = image_per_frame_ff;
      end
   end

   assign image_per_frame = image_per_frame_ff;

endmodule

/* rtl/core/jfbs_scan.sv */
// Marker scan state machine, segment skip counter and frame byte counter.
module jfbs_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [jfbs_pkg::BYTE_WIDTH-1:0]  data_byte,
   input  logic                             image_per_frame,
   output jfbs_pkg::scan_result_type        result,
   output jfbs_pkg::scan_status_type        status
);
   import jfbs_pkg::*;

   scan_state_type            state_ff, state_in;
   logic                      have_high_ff, have_high_in;
   logic                      have_low_ff, have_low_in;
   logic [LENGTH_WIDTH-1:0]   skip_ff, skip_in;
   logic                      fields_seen_ff, fields_seen_in;
   logic [SIZE_WIDTH-1:0]     offset_ff, offset_in;

   logic [SIZE_WIDTH-1:0]     offset_inc;
   logic [LENGTH_WIDTH:0]     seg_len;
   logic [LENGTH_WIDTH-1:0]   skip_dec;
   logic                      is_prefix;
   logic                      is_eoi;
   logic                      no_segment;
   logic                      frame_done;
   logic                      bad_start;

   assign is_prefix  = (data_byte == MARKER_PREFIX);
   assign is_eoi     = (data_byte == CODE_EOI);
   assign no_segment = data_byte inside {[CODE_RST_LO:CODE_RST_HI], CODE_TEM, CODE_STUFF};
   assign frame_done = (state_ff == ST_CODE) && is_eoi && (image_per_frame || fields_seen_ff);
   assign bad_start  = !(state_ff inside {ST_SOI, ST_SEARCH, ST_CODE, ST_LENGTH}) &&
                       !is_prefix;
   assign offset_inc = (offset_ff == OFFSET_MAX) ? OFFSET_MAX : offset_ff + SIZE_WIDTH'(1);
   assign seg_len    = {1'b0, skip_ff} + {{(LENGTH_WIDTH+1-BYTE_WIDTH){1'b0}}, data_byte};
   assign skip_dec   = (skip_ff != '0) ? skip_ff - LENGTH_WIDTH'(1) : skip_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SOI: begin
            if (data_byte == CODE_SOI) begin
               state_in = ST_SEARCH;
            end else if (!is_prefix) begin
               state_in = ST_START;
            end
         end
         ST_SEARCH: begin
            if (is_prefix) begin
               state_in = ST_CODE;
            end
         end
         ST_CODE: begin
            if (is_eoi) begin
               state_in = ST_START;
            end else if (no_segment) begin
               state_in = ST_SEARCH;
            end else if (!is_prefix) begin
               state_in = ST_LENGTH;
            end
         end
         ST_LENGTH: begin
            if (have_high_ff && !have_low_ff) begin
               if (seg_len < (LENGTH_WIDTH+1)'(3)) begin
                  state_in = ST_SEARCH;
               end
            end else if (have_high_ff && skip_dec == '0) begin
               state_in = ST_SEARCH;
            end
         end
         default: begin
            state_in = is_prefix ? ST_SOI : ST_START;
         end
      endcase
   end

   // Counters, flags and result.
   always_comb begin
      have_high_in   = have_high_ff;
      have_low_in    = have_low_ff;
      skip_in        = skip_ff;
      fields_seen_in = fields_seen_ff;
      offset_in      = offset_inc;
      result.valid      = 1'b0;
      result.kind       = KIND_FRAME;
      result.frame_size = offset_inc;
      case (state_ff)
         ST_CODE: begin
            if (is_eoi) begin
               if (frame_done) begin
                  result.valid   = 1'b1;
                  fields_seen_in = 1'b0;
                  offset_in      = '0;
               end else begin
                  fields_seen_in = 1'b1;
               end
            end else if (!no_segment && !is_prefix) begin
               have_high_in = 1'b0;
               have_low_in  = 1'b0;
               skip_in      = '0;
            end
         end
         ST_LENGTH: begin
            if (!have_high_ff) begin
               have_high_in = 1'b1;
               skip_in      = {data_byte, {(LENGTH_WIDTH-BYTE_WIDTH){1'b0}}};
            end else if (!have_low_ff) begin
               have_low_in = 1'b1;
               // Lengths below two count as two: nothing to skip.
               skip_in = (seg_len < (LENGTH_WIDTH+1)'(2)) ? '0 :
                         LENGTH_WIDTH'(seg_len - (LENGTH_WIDTH+1)'(2));
            end else begin
               skip_in = skip_dec;
            end
         end
         ST_SOI, ST_SEARCH: begin
         end
         default: begin
            if (bad_start) begin
               result.valid      = 1'b1;
               result.kind       = KIND_INVALID;
               result.frame_size = '0;
               have_high_in      = 1'b0;
               have_low_in       = 1'b0;
               skip_in           = '0;
               fields_seen_in    = 1'b0;
               offset_in         = '0;
            end
         end
      endcase
      if (frame_done) begin
         have_high_in = 1'b0;
         have_low_in  = 1'b0;
         skip_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_START;
         have_high_ff   <= 1'b0;
         have_low_ff    <= 1'b0;
         skip_ff        <= '0;
         fields_seen_ff <= 1'b0;
         offset_ff      <= '0;
      end else if (advance) begin
         state_ff       <= state_in;
         have_high_ff   <= have_high_in;
         have_low_ff    <= have_low_in;
         skip_ff        <= skip_in;
         fields_seen_ff <= fields_seen_in;
         offset_ff      <= offset_in;
      end
   end

   assign status.state       = state_ff;
   assign status.byte_offset = offset_ff;

endmodule

/* rtl/core/jpeg_frame_boundary_scanner.sv */
// Top level: input register, scan core, result register and configuration port.
// A byte accepted into the input register is scanned when the scanner advances; its
//   result, if any, is captured in the result register and shows on rsp_valid.
// Throughput: one byte per clock, set by the scan update between the input register
//   and the result register; a stalled result holds both stages.
// Reset (synchronous, active high): empties both registers, sets the scanner to
//   await the 0xFF that opens a frame and clears the field mode (two-field mode).
module jpeg_frame_boundary_scanner (
   input  logic                                 clock,
   input  logic                                 reset,
   // input byte channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [jfbs_pkg::BYTE_WIDTH-1:0]      req_data_byte,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_result_kind,
   output logic [jfbs_pkg::SIZE_WIDTH-1:0]      rsp_frame_size,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [jfbs_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [jfbs_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [jfbs_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                 pready
);
   import jfbs_pkg::*;

   // Input register: holds one accepted item until the scanner takes it.
   logic                    in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0]   in_byte_ff, in_byte_in;

   // Result register.
   logic                    out_valid_ff, out_valid_in;
   result_kind_type         out_kind_ff, out_kind_in;
   logic [SIZE_WIDTH-1:0]   out_size_ff, out_size_in;

   logic                    image_per_frame;
   logic                    req_accept;
   logic                    out_blocked;
   logic                    advance;
   scan_result_type         scan_result;
   scan_status_type         scan_status;

   jfbs_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .image_per_frame (image_per_frame)
   );

   // The scanner moves only when a waiting result is not stuck downstream, so
   // a result register is never overwritten before it is taken.
   assign out_blocked = out_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;

   jfbs_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .data_byte       (in_byte_ff),
      .image_per_frame (image_per_frame),
      .result          (scan_result),
      .status          (scan_status)
   );

   // Load a new byte on accept, drop the held one once scanned.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Capture a result when the scanned byte yields one; drop it once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_size_in  = out_size_ff;
      if (advance && scan_result.valid) begin
         out_valid_in = 1'b1;
         out_kind_in  = scan_result.kind;
         out_size_in  = scan_result.frame_size;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_kind_ff <= out_kind_in;
      out_size_ff <= out_size_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_frame_size  = out_size_ff;

   // An invalid frame start always reports a size of zero.
   a_invalid_size_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_kind_ff == KIND_INVALID) |-> (out_size_ff == '0))
      else $error("invalid-start result carries a nonzero frame size");

   // Every result restarts the frame: scanner back at start with a cleared count.
   a_restart_after_result: assert property (@(posedge clock) disable iff (reset)
      advance && scan_result.valid |=>
         (scan_status.state == ST_START) && (scan_status.byte_offset == '0))
      else $error("scanner did not restart after a result");

   // A held byte that the scanner did not take stays in the input register.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost or changed an unscanned byte");

   // A scanned byte must not produce a result while one is stuck downstream.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_blocked |-> !advance)
      else $error("scanner advanced while the result register was blocked");

endmodule

/* verif/tb_top.sv */
// Testbench for the motion JPEG frame boundary scanner: directed and random byte streams.
`timescale 1ns / 100ps

module tb_top;
   import jfbs_pkg::*;

   // Pacing modes for the byte sender and the result receiver.
   typedef enum int {
      PACE_NONE,
      PACE_SENDER,
      PACE_RECEIVER,
      PACE_BOTH
   } pace_mode_type;

   // One frame report as the block should deliver it.
   typedef struct {
      result_kind_type       kind;
      logic [SIZE_WIDTH-1:0] size;
   } frame_report_type;

   localparam logic [CSR_ADDR_WIDTH-1:0] IMAGE_PER_FRAME_ADDR = {REG_IMAGE_PER_FRAME, 2'b00};
   localparam int SETTLE_CYCLES  = 4;     // time from accept to result, plus margin
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_BYTES    = 180;
   localparam int DRAIN_LIMIT    = 20000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [BYTE_WIDTH-1:0]     req_data_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_result_kind;
   logic [SIZE_WIDTH-1:0]     rsp_frame_size;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   jpeg_frame_boundary_scanner dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_frame_size  (rsp_frame_size),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // ---------------------------------------------------------------------
   // Scan predictor state: a private copy of the block's state and register
   // ---------------------------------------------------------------------
   scan_state_type          scan_st;
   logic                    len_hi_seen;
   logic                    len_lo_seen;
   logic [LENGTH_WIDTH-1:0] skip_left;
   logic                    second_field;
   logic [SIZE_WIDTH-1:0]   frame_offset;
   logic                    one_image_mode;

   frame_report_type pending_reports[$];

   int mismatch_count  = 0;
   int bytes_sent      = 0;
   int frames_checked  = 0;
   int invalid_checked = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // Clock: 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if it hangs.
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   // Drop back to the frame-start state; the register survives.
   function automatic void restart_scan();
      scan_st      = ST_START;
      len_hi_seen  = 1'b0;
      len_lo_seen  = 1'b0;
      skip_left    = '0;
      second_field = 1'b0;
      frame_offset = '0;
   endfunction

   // Advance the predictor by one accepted byte; queue a report if one is due.
   function automatic void scan_predict(input logic [BYTE_WIDTH-1:0] b);
      logic [LENGTH_WIDTH:0] seg_len;
      logic [SIZE_WIDTH-1:0] next_size;
      frame_report_type      report;
      bit                    reported;
      reported = 1'b0;
      case (scan_st)
         ST_SOI: begin
            if (b == CODE_SOI)
               scan_st = ST_SEARCH;
            else if (b != MARKER_PREFIX)
               scan_st = ST_START;   // no SOI after 0xFF: back to frame start, keep counting
         end
         ST_SEARCH: begin
            if (b == MARKER_PREFIX)
               scan_st = ST_CODE;
         end
         ST_CODE: begin
            if (b == CODE_EOI) begin
               next_size = (frame_offset == OFFSET_MAX) ? OFFSET_MAX
                                                        : frame_offset + SIZE_WIDTH'(1);
               if (one_image_mode || second_field) begin
                  report.kind = KIND_FRAME;
                  report.size = next_size;
                  pending_reports.push_back(report);
                  restart_scan();
                  reported = 1'b1;
               end else begin
                  // first field done: the second must open with 0xFF again
                  second_field = 1'b1;
                  scan_st      = ST_START;
               end
            end else if ((b >= CODE_RST_LO && b <= CODE_RST_HI) || b == CODE_TEM ||
                         b == CODE_STUFF) begin
               scan_st = ST_SEARCH;
            end else if (b != MARKER_PREFIX) begin
               scan_st     = ST_LENGTH;
               len_hi_seen = 1'b0;
               len_lo_seen = 1'b0;
               skip_left   = '0;
            end
         end
         ST_LENGTH: begin
            if (!len_hi_seen) begin
               len_hi_seen = 1'b1;
               skip_left   = {b, 8'h00};
            end else if (!len_lo_seen) begin
               seg_len     = {1'b0, skip_left} + (LENGTH_WIDTH+1)'(b);
               len_lo_seen = 1'b1;
               // lengths below 2 skip nothing
               skip_left   = (seg_len < 2) ? '0 : seg_len[LENGTH_WIDTH-1:0] - 16'd2;
               if (skip_left == 0)
                  scan_st = ST_SEARCH;
            end else begin
               if (skip_left != 0)
                  skip_left = skip_left - LENGTH_WIDTH'(1);
               if (skip_left == 0)
                  scan_st = ST_SEARCH;
            end
         end
         default: begin
            if (b == MARKER_PREFIX) begin
               scan_st = ST_SOI;
            end else begin
               report.kind = KIND_INVALID;
               report.size = '0;
               pending_reports.push_back(report);
               restart_scan();
               reported = 1'b1;
            end
         end
      endcase
      if (!reported && frame_offset != OFFSET_MAX)
         frame_offset = frame_offset + SIZE_WIDTH'(1);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("tb: mismatch at %0t: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------
   // Result checking: compare each accepted result with the oldest report
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      frame_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d size %0d",
                                      rsp_result_kind, rsp_frame_size));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_result_kind !== want.kind || rsp_frame_size !== want.size)
               report_mismatch($sformatf("expected kind %0d size %0d, got kind %0d size %0d",
                                         want.kind, want.size, rsp_result_kind,
                                         rsp_frame_size));
            if (want.kind == KIND_FRAME)
               frames_checked++;
            else
               invalid_checked++;
         end
      end
   end

   // Receiver: stall at random at the rate of the current pacing mode.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < receiver_stall_pct);
   end

   task automatic set_pacing(input pace_mode_type mode);
      case (mode)
         PACE_SENDER:   begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
         PACE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
         PACE_BOTH:     begin sender_idle_pct = 9;  receiver_stall_pct = 9;  end
         default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   // Send one item: idle at random, hold the byte until accepted, then predict.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      scan_predict(value);
      bytes_sent++;
   endtask

   // Stop sending and hold until every predicted report has come out.
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   // Read the field-mode register and check it against the predictor's copy.
   task automatic read_image_per_frame();
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= IMAGE_PER_FRAME_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (prdata !== {{(CSR_DATA_WIDTH-1){1'b0}}, one_image_mode})
         report_mismatch($sformatf("field mode read %0h, expected %0d",
                                   prdata, one_image_mode));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write the field-mode register once the block has gone quiet, then read it back.
   task automatic write_image_per_frame(input logic value);
      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= IMAGE_PER_FRAME_ADDR;
      pwdata  <= {{(CSR_DATA_WIDTH-1){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      one_image_mode = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      read_image_per_frame();
   endtask

   // Steer the stream back to a frame start, whatever state a broken stream left.
   task automatic sync_to_frame_start();
      while (scan_st != ST_START) begin
         case (scan_st)
            ST_SEARCH: send_byte(MARKER_PREFIX);
            ST_CODE:   send_byte(CODE_EOI);
            default:   send_byte(CODE_STUFF);   // SOI miss, zero length, skipped data
         endcase
      end
   endtask

   // One image with random segments and entropy data; cut it off early if asked.
   task automatic send_random_image(input bit cut_short);
      int                    seg_count;
      int                    data_count;
      int                    seg_len;
      logic [BYTE_WIDTH-1:0] code;
      logic [BYTE_WIDTH-1:0] b;
      send_byte(MARKER_PREFIX);
      repeat ($urandom_range(0, 2)) send_byte(MARKER_PREFIX);
      send_byte(CODE_SOI);
      seg_count = $urandom_range(0, 3);
      for (int s = 0; s < seg_count; s++) begin
         if (cut_short && $urandom_range(0, 3) == 0)
            return;
         send_byte(MARKER_PREFIX);
         if ($urandom_range(0, 3) == 0)
            send_byte(MARKER_PREFIX);
         // pick a code that carries a length
         code = 8'($urandom_range(0, 255));
         if ((code >= CODE_RST_LO && code <= CODE_EOI) || code == CODE_TEM ||
             code == CODE_STUFF || code == MARKER_PREFIX)
            code = 8'hE0 | 8'($urandom_range(0, 15));
         send_byte(code);
         seg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 400)
                                               : $urandom_range(0, 12);
         send_byte(8'(seg_len >> 8));
         send_byte(8'(seg_len));
         for (int k = 2; k < seg_len; k++)
            send_byte(8'($urandom_range(0, 255)));
      end
      data_count = $urandom_range(0, 40);
      for (int k = 0; k < data_count; k++) begin
         if (cut_short && $urandom_range(0, 15) == 0)
            return;
         b = 8'($urandom_range(0, 255));
         send_byte(b);
         if (b == MARKER_PREFIX) begin
            case ($urandom_range(0, 3))
               0:       send_byte(CODE_STUFF);
               1:       send_byte(CODE_TEM);
               2:       send_byte(CODE_RST_LO + 8'($urandom_range(0, 7)));
               default: begin
                  send_byte(MARKER_PREFIX);
                  send_byte(CODE_STUFF);
               end
            endcase
         end
      end
      send_byte(MARKER_PREFIX);
      if ($urandom_range(0, 3) == 0)
         send_byte(MARKER_PREFIX);
      send_byte(CODE_EOI);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // An invalid start of 0x00 and a 0xFF not followed by SOI.
   task automatic test_invalid_start();
      set_pacing(PACE_NONE);
      read_image_per_frame();
      send_byte(CODE_STUFF);      // not 0xFF at frame start: invalid report
      send_byte(MARKER_PREFIX);
      send_byte(8'h55);           // no SOI: back to frame start, no report
   endtask

   // Two-field mode: fill, TEM, restart markers, stuffed zero, a short length,
   // then a second field that fails to open with 0xFF.
   task automatic test_two_field_frame();
      set_pacing(PACE_BOTH);
      send_byte(MARKER_PREFIX);
      send_byte(MARKER_PREFIX);
      send_byte(CODE_SOI);
      send_byte(MARKER_PREFIX);
      send_byte(CODE_TEM);
      send_byte(MARKER_PREFIX);
      send_byte(CODE_RST_LO);
      send_byte(MARKER_PREFIX);
      send_byte(CODE_RST_HI);
      send_byte(MARKER_PREFIX);
      send_byte(CODE_STUFF);
      send_byte(MARKER_PREFIX);
      send_byte(8'hC4);
      send_byte(8'h00);
      send_byte(8'h01);           // length below 2: nothing to skip
      send_byte(MARKER_PREFIX);
      send_byte(CODE_EOI);        // first field ends, no report yet
      send_byte(8'h12);           // second field start is bad
   endtask

   // One-image mode: the shortest frame reports at its own EOI.
   task automatic test_single_image_frame();
      write_image_per_frame(1'b1);
      set_pacing(PACE_RECEIVER);
      send_byte(MARKER_PREFIX);
      send_byte(CODE_SOI);
      send_byte(MARKER_PREFIX);
      send_byte(CODE_EOI);
   endtask

   // Random streams: mostly well-formed images, plus broken images, noise and
   // bad starts, over every pacing mode in both field modes.
   task automatic test_random_streams();
      int  phase_end;
      int  pick;
      bit  paused;
      logic [BYTE_WIDTH-1:0] b;
      paused = 1'b0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            write_image_per_frame(1'b1);
         else if (phase == RANDOM_PHASES / 2)
            write_image_per_frame(1'b0);
         set_pacing(pace_mode_type'(phase % 4));
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) begin
            // hold off once mid-stream until the block has emptied out
            if (phase == 2 && !paused && bytes_sent > phase_end - PHASE_BYTES / 2) begin
               wait_for_reports();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // noise from wherever the scanner stands; keep segment lengths short
               repeat ($urandom_range(1, 8)) begin
                  if (scan_st == ST_LENGTH && !len_hi_seen)
                     b = 8'($urandom_range(0, 1));
                  else
                     b = 8'($urandom_range(0, 255));
                  send_byte(b);
               end
            end else begin
               sync_to_frame_start();
               if (pick < 20)
                  send_byte(8'($urandom_range(0, 254)));   // bad frame start
               else
                  send_random_image(pick < 30);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int guard;
      one_image_mode = 1'b0;
      restart_scan();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_invalid_start();
      test_two_field_frame();
      test_single_image_frame();
      test_random_streams();

      // Drain: wait out every report, with a limit, then let the pipe settle.
      req_valid <= 1'b0;
      guard = 0;
      while (pending_reports.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0)
         report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

      $display("tb: sent %0d bytes in %0d random phases over all pacing modes, both field modes",
               bytes_sent, RANDOM_PHASES);
      $display("tb: checked %0d frame sizes and %0d invalid starts, %0d mismatches",
               frames_checked, invalid_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
